// File: src/wsfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the WebSocket frame deframer
// Holds the parse phase encoding, the result beat struct and header codes.
// ---------------------------------------------------------------------------
package wsfd_pkg;

   // Widths fixed by the field definitions
   localparam int BYTE_W = 8;
   localparam int OPC_W  = 4;
   localparam int LEN_W  = 13;
   localparam int DECL_W = 64;
   localparam int KEY_W  = 32;

   // Default hard cap on delivered payload bytes per frame
   localparam int PAYLOAD_CAP_DEFAULT = 4096;

   // Reset value of the payload limit register
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

   // Seven-bit length codes that announce an extended length
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Extended length sizes in bytes
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   // Mask key size in bytes
   localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

   // Parse phase, one-hot
   typedef enum logic [5:0] {
      PH_HDR0 = 6'b000001,
      PH_HDR1 = 6'b000010,
      PH_EXT  = 6'b000100,
      PH_MASK = 6'b001000,
      PH_DATA = 6'b010000,
      PH_DROP = 6'b100000
   } phase_type;

   // One result beat
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [OPC_W-1:0]  frame_opcode;
      logic              last_byte;
      logic              empty_frame;
      logic              truncated;
   } rsp_type;

endpackage

// File: src/wsfd_in_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_in_reg: input byte register
// Captures one stream byte per beat and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module wsfd_in_reg
   import wsfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              byte_valid,
   output logic [BYTE_W-1:0] byte_data,
   input  logic              byte_take
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] data_ff;

   // Accept a new beat when empty or when the held byte leaves this cycle
   assign req_ready = !valid_ff || byte_take;
   assign valid_in  = req_valid || (valid_ff && !byte_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload on an accepted beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_in_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

// File: src/wsfd_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_parser: frame header parser and payload unmasker
// Walks the header bytes, splits the length into delivered and dropped
// bytes, unmasks the payload and builds at most one result per byte.
// ---------------------------------------------------------------------------
module wsfd_parser
   import wsfd_pkg::*;
#(
   parameter int PAYLOAD_CAP = PAYLOAD_CAP_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              byte_fire,
   input  logic [BYTE_W-1:0] byte_data,
   output logic              res_valid,
   output rsp_type           res
);

   phase_type          phase_ff,       phase_in;
   logic [3:0]         ext_left_ff,    ext_left_in;
   logic [DECL_W-1:0]  decl_len_ff,    decl_len_in;
   logic [KEY_W-1:0]   mask_key_ff,    mask_key_in;
   logic               mask_present_ff, mask_present_in;
   logic [2:0]         mask_left_ff,   mask_left_in;
   logic [OPC_W-1:0]   opcode_ff,      opcode_in;
   logic [LEN_W-1:0]   emit_left_ff,   emit_left_in;
   logic [DECL_W-1:0]  drop_left_ff,   drop_left_in;
   logic [1:0]         lane_ff,        lane_in;
   logic [LEN_W-1:0]   max_len_ff;

   logic [LEN_W-1:0]   cap_eff;
   logic [DECL_W-1:0]  cap_wide;
   logic [DECL_W-1:0]  len_val;
   logic               len_known;
   logic               hdr_done;
   logic               mask_now;
   logic [BYTE_W-1:0]  key_byte;
   logic [6:0]         len7;

   // Saturate the limit register to the hard cap
   always_comb begin
      if (32'(max_len_ff) > PAYLOAD_CAP) begin
         cap_eff = LEN_W'(PAYLOAD_CAP);
      end else begin
         cap_eff = max_len_ff;
      end
   end

   assign cap_wide = DECL_W'(cap_eff);
   assign len7     = byte_data[6:0];

   // Pick the mask key byte for the current lane, first key byte in the top
   always_comb begin
      case (lane_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Step the parse state for one byte
   always_comb begin
      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      decl_len_in     = decl_len_ff;
      mask_key_in     = mask_key_ff;
      mask_present_in = mask_present_ff;
      mask_left_in    = mask_left_ff;
      opcode_in       = opcode_ff;
      emit_left_in    = emit_left_ff;
      drop_left_in    = drop_left_ff;
      lane_in         = lane_ff;
      len_known       = 1'b0;
      hdr_done        = 1'b0;
      len_val         = decl_len_ff;
      mask_now        = mask_present_ff;
      res_valid       = 1'b0;
      res.payload_byte = '0;
      res.frame_opcode = opcode_ff;
      res.last_byte    = 1'b0;
      res.empty_frame  = 1'b0;
      res.truncated    = 1'b0;

      if (byte_fire) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_present_in = byte_data[7];
               mask_now        = byte_data[7];
               decl_len_in     = '0;
               if (len7 == LEN_CODE_EXT16) begin
                  ext_left_in = EXT16_BYTES;
                  phase_in    = PH_EXT;
               end else if (len7 == LEN_CODE_EXT64) begin
                  ext_left_in = EXT64_BYTES;
                  phase_in    = PH_EXT;
               end else begin
                  len_val     = DECL_W'(len7);
                  decl_len_in = len_val;
                  len_known   = 1'b1;
               end
            end
            PH_EXT: begin
               len_val     = {decl_len_ff[DECL_W-9:0], byte_data};
               decl_len_in = len_val;
               ext_left_in = ext_left_ff - 4'd1;
               if (ext_left_in == 4'd0) begin
                  len_known = 1'b1;
               end
            end
            PH_MASK: begin
               mask_key_in  = {mask_key_ff[KEY_W-9:0], byte_data};
               mask_left_in = mask_left_ff - 3'd1;
               if (mask_left_in == 3'd0) begin
                  hdr_done = 1'b1;
               end
            end
            PH_DATA: begin
               res_valid        = 1'b1;
               res.payload_byte = mask_present_ff ? (byte_data ^ key_byte) : byte_data;
               lane_in          = lane_ff + 2'd1;
               emit_left_in     = emit_left_ff - LEN_W'(1);
               if (emit_left_in == '0) begin
                  res.last_byte = 1'b1;
                  phase_in      = (drop_left_ff != '0) ? PH_DROP : PH_HDR0;
               end
            end
            PH_DROP: begin
               drop_left_in = drop_left_ff - DECL_W'(1);
               if (drop_left_in == '0) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               // First header byte, also the landing spot for stray codes
               opcode_in = byte_data[OPC_W-1:0];
               phase_in  = PH_HDR1;
            end
         endcase

         // Split the known length into delivered and dropped bytes
         if (len_known) begin
            if (len_val > cap_wide) begin
               emit_left_in = cap_eff;
               drop_left_in = len_val - cap_wide;
            end else begin
               emit_left_in = len_val[LEN_W-1:0];
               drop_left_in = '0;
            end
            if (mask_now) begin
               mask_left_in = MASK_KEY_BYTES;
               mask_key_in  = '0;
               phase_in     = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end

         // Header complete: start payload or emit the empty-frame marker
         if (hdr_done) begin
            lane_in = '0;
            if (emit_left_in == '0) begin
               res_valid       = 1'b1;
               res.last_byte   = 1'b1;
               res.empty_frame = 1'b1;
               phase_in        = (drop_left_in != '0) ? PH_DROP : PH_HDR0;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end

      res.truncated = (drop_left_in != '0);
   end

   // Hold the parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         ext_left_ff     <= '0;
         decl_len_ff     <= '0;
         mask_key_ff     <= '0;
         mask_present_ff <= 1'b0;
         mask_left_ff    <= '0;
         opcode_ff       <= '0;
         emit_left_ff    <= '0;
         drop_left_ff    <= '0;
         lane_ff         <= '0;
      end else begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         decl_len_ff     <= decl_len_in;
         mask_key_ff     <= mask_key_in;
         mask_present_ff <= mask_present_in;
         mask_left_ff    <= mask_left_in;
         opcode_ff       <= opcode_in;
         emit_left_ff    <= emit_left_in;
         drop_left_ff    <= drop_left_in;
         lane_ff         <= lane_in;
      end
   end

   // Write the payload limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

endmodule

// File: src/wsfd_out_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_out_reg: result register
// Holds one result beat until the consumer takes it.
// ---------------------------------------------------------------------------
module wsfd_out_reg
   import wsfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   // Free when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = res_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result beat
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: src/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top: WebSocket receive-side frame deframer
// Parses a byte stream into frames and delivers unmasked payload bytes
// tagged with the opcode, capped at a programmable per-frame limit.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Beat contents
//   req      in         req_valid/ready    one stream byte
//   rsp      out        rsp_valid/ready    payload byte, opcode, last, empty, truncated
//   csr      in         csr_wr_en          payload limit (13 bits), no read-back
//
// One byte is accepted per clock while the result register has room; a
// registered byte is parsed when there is room, and its result, if any,
// is loaded into the result register as the byte is taken. Throughput is
// set by the parser step. A stalled result register stalls parsing, which
// back-pressures req_ready. Synchronous reset returns the parser to the
// first header byte and the limit to 4096.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top
   import wsfd_pkg::*;
#(
   parameter int PAYLOAD_CAP = PAYLOAD_CAP_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [OPC_W-1:0]  rsp_frame_opcode,
   output logic              rsp_last_byte,
   output logic              rsp_empty_frame,
   output logic              rsp_truncated,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data
);

   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   logic              byte_fire;
   logic              can_load;
   logic              res_valid;
   rsp_type           res;
   rsp_type           rsp;

   // Parse the held byte whenever the result register has room
   assign byte_fire = byte_valid && can_load;

   wsfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .byte_take   (byte_fire)
   );

   wsfd_parser #(
      .PAYLOAD_CAP (PAYLOAD_CAP)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_fire   (byte_fire),
      .byte_data   (byte_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Unpack the result beat onto the ports
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_frame_opcode = rsp.frame_opcode;
   assign rsp_last_byte    = rsp.last_byte;
   assign rsp_empty_frame  = rsp.empty_frame;
   assign rsp_truncated    = rsp.truncated;

endmodule
